/* sv/ultrasonic_echo_ranger_assert.svh */
// ============================================================================
// Ultrasonic echo ranger assertion macros
// Concurrent assertion shorthands used by the ranger top level.
// ============================================================================
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define UER_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ranger assertion failed");

// Next-cycle implication, checked out of reset
`define UER_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ranger assertion failed");

`endif

/* sv/uer_pkg.sv */
// ============================================================================
// Ultrasonic echo ranger package
// Shared types, register indexes, defaults and the width-to-distance scaling.
// ============================================================================
package uer_pkg;

    localparam int COUNT_BITS_DEF         = 17;
    localparam int TRIGGER_LOW_TICKS_DEF  = 2;
    localparam int TRIGGER_HIGH_TICKS_DEF = 10;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 20;
    localparam int INTERVAL_BITS  = 20;
    localparam int TIMEOUT_BITS   = 16;
    localparam int DIST_BITS      = 14;
    localparam int WIDTH_OUT_BITS = 17;
    localparam int WIDTH_OUT_MAX  = 131071;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE           = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MEASURE_INTERVAL = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ECHO_TIMEOUT     = 2'd2;

    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 20'd50000;
    localparam logic [TIMEOUT_BITS-1:0]  TIMEOUT_RESET  = 16'd30000;

    // floor(w * 343 / 2000) == (w * ceil(343 * 2^27 / 2000)) >> 27 for w < 2^16
    localparam int               DIST_SHIFT = 27;
    localparam int               RECIP_BITS = 25;
    localparam int               PROD_BITS  = TIMEOUT_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] DIST_RECIP = 25'd23018341;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_NO_RESPONSE,
        EV_STUCK_HIGH,
        EV_TOO_LONG
    } event_t;

    typedef struct packed {
        logic                     enable;
        logic [INTERVAL_BITS-1:0] measure_interval_us;
        logic [TIMEOUT_BITS-1:0]  echo_timeout_us;
    } cfg_t;

    typedef struct packed {
        logic                      trigger_level;
        logic                      sample_valid;
        logic [DIST_BITS-1:0]      distance_mm;
        logic [WIDTH_OUT_BITS-1:0] echo_width_us;
        event_t                    event_code;
    } result_t;

    function automatic logic [DIST_BITS-1:0] mm_from_width(input logic [TIMEOUT_BITS-1:0] w);
        logic [PROD_BITS-1:0] prod;
        prod = PROD_BITS'(w) * PROD_BITS'(DIST_RECIP);
        return prod[DIST_SHIFT +: DIST_BITS];
    endfunction

endpackage

/* sv/uer_core.sv */
// ============================================================================
// Ultrasonic echo ranger tick engine
// Trigger sequencing, echo edge timing and result formation, one tick per
// advance.
// ============================================================================
module uer_core #(
    parameter int COUNT_BITS         = uer_pkg::COUNT_BITS_DEF,
    parameter int TRIGGER_LOW_TICKS  = uer_pkg::TRIGGER_LOW_TICKS_DEF,
    parameter int TRIGGER_HIGH_TICKS = uer_pkg::TRIGGER_HIGH_TICKS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             echo_level,
    input  uer_pkg::cfg_t    cfg,
    output uer_pkg::result_t result
);
    import uer_pkg::*;

    localparam int MAX_TICKS = (TRIGGER_LOW_TICKS > TRIGGER_HIGH_TICKS) ?
                               TRIGGER_LOW_TICKS : TRIGGER_HIGH_TICKS;
    localparam int STEP_BITS = $clog2(MAX_TICKS + 1);

    typedef enum logic [2:0] {
        PH_ARMED,
        PH_TRIG_LOW,
        PH_TRIG_HIGH,
        PH_WAIT_RISE,
        PH_WAIT_FALL
    } phase_t;

    phase_t                   phase_reg, phase_next, phase_cur;
    logic [STEP_BITS-1:0]     step_reg, step_next, step_cur, step_inc;
    logic [INTERVAL_BITS-1:0] interval_reg, interval_next;
    logic [INTERVAL_BITS:0]   interval_inc;
    logic [COUNT_BITS-1:0]    since_reg, since_next, since_inc;
    logic [COUNT_BITS-1:0]    width_reg, width_next, width_inc;
    logic [COUNT_BITS-1:0]    timeout_ext;
    logic                     prev_echo_reg;
    logic                     rising, falling, mtick;
    result_t                  result_reg, result_next;

    assign rising       = echo_level & ~prev_echo_reg;
    assign falling      = ~echo_level & prev_echo_reg;
    assign mtick        = (interval_reg == '0);
    assign interval_inc = {1'b0, interval_reg} + 1'b1;
    assign since_inc    = (since_reg == '1) ? since_reg : since_reg + 1'b1;
    assign width_inc    = (width_reg == '1) ? width_reg : width_reg + 1'b1;
    assign timeout_ext  = COUNT_BITS'(cfg.echo_timeout_us);
    assign step_inc     = step_cur + 1'b1;

    always_comb begin
        phase_next    = phase_reg;
        step_next     = step_reg;
        interval_next = interval_reg;
        since_next    = since_reg;
        width_next    = width_reg;
        phase_cur     = phase_reg;
        step_cur      = step_reg;

        result_next.trigger_level = 1'b0;
        result_next.sample_valid  = 1'b0;
        result_next.distance_mm   = '0;
        result_next.echo_width_us = '0;
        result_next.event_code    = EV_NONE;

        if (!cfg.enable) begin
            phase_next                = PH_ARMED;
            step_next                 = '0;
            interval_next             = '0;
            since_next                = '0;
            width_next                = '0;
            result_next.trigger_level = 1'b1;
        end else begin
            interval_next = (interval_inc >= {1'b0, cfg.measure_interval_us}) ?
                            '0 : interval_inc[INTERVAL_BITS-1:0];

            if (phase_reg == PH_ARMED && mtick) begin
                phase_cur = PH_TRIG_LOW;
                step_cur  = '0;
            end
            phase_next = phase_cur;
            step_next  = step_cur;

            case (phase_cur)
                PH_ARMED: begin
                end
                PH_TRIG_LOW: begin
                    if (step_inc >= STEP_BITS'(TRIGGER_LOW_TICKS)) begin
                        phase_next = PH_TRIG_HIGH;
                        step_next  = '0;
                    end else begin
                        step_next  = step_inc;
                    end
                end
                PH_TRIG_HIGH: begin
                    result_next.trigger_level = 1'b1;
                    if (step_inc >= STEP_BITS'(TRIGGER_HIGH_TICKS)) begin
                        phase_next = PH_WAIT_RISE;
                        step_next  = '0;
                        since_next = '0;
                    end else begin
                        step_next  = step_inc;
                    end
                end
                PH_WAIT_RISE: begin
                    if (rising) begin
                        phase_next = PH_WAIT_FALL;
                        width_next = '0;
                    end else if (mtick && since_reg >= timeout_ext) begin
                        result_next.event_code = EV_NO_RESPONSE;
                        phase_next             = PH_ARMED;
                    end else begin
                        since_next = since_inc;
                    end
                end
                PH_WAIT_FALL: begin
                    width_next = width_inc;
                    if (falling) begin
                        result_next.echo_width_us =
                            (width_inc > COUNT_BITS'(WIDTH_OUT_MAX)) ?
                            WIDTH_OUT_BITS'(WIDTH_OUT_MAX) : WIDTH_OUT_BITS'(width_inc);
                        if (width_inc > timeout_ext) begin
                            result_next.event_code = EV_TOO_LONG;
                        end else begin
                            result_next.sample_valid = 1'b1;
                            result_next.distance_mm  =
                                mm_from_width(width_inc[TIMEOUT_BITS-1:0]);
                        end
                        phase_next = PH_ARMED;
                    end else if (rising) begin
                        width_next = '0;
                    end else if (mtick) begin
                        result_next.event_code = EV_STUCK_HIGH;
                        phase_next             = PH_ARMED;
                    end
                end
                default: begin
                    phase_next = PH_ARMED;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_ARMED;
            step_reg      <= '0;
            interval_reg  <= '0;
            since_reg     <= '0;
            width_reg     <= '0;
            prev_echo_reg <= 1'b0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            interval_reg  <= interval_next;
            since_reg     <= since_next;
            width_reg     <= width_next;
            prev_echo_reg <= echo_level;
            result_reg    <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* sv/ultrasonic_echo_ranger.sv */
// ============================================================================
// Ultrasonic echo ranger
// Drives the sensor trigger pulse, times the echo and reports distance in
// millimetres or a fault event, one result transaction per tick transaction.
// ============================================================================
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  s_ tick  | s_valid / s_ready      | s_echo_level
//  m_ result| m_valid / m_ready      | m_trigger_level, m_sample_valid,
//           |                        | m_distance_mm, m_echo_width_us, m_event_code
//  cfg      | cfg_we (no wait)       | cfg_index, cfg_wdata
//
//  One tick transaction per cycle sustained while m_ready is high; the result
//  is registered at the edge that moves the tick out of the input register,
//  and can be taken from the following edge on.
//  The tick engine is a single registered pass; its longest path is the
//  16 x 25 bit scaling multiply on a falling echo edge.
//  A stalled m_ready holds the result register and backs up into s_ready.
//  Synchronous active-low reset; all registers but echo_reg and result_reg reset.
// ============================================================================
`include "ultrasonic_echo_ranger_assert.svh"

module ultrasonic_echo_ranger #(
    parameter int COUNT_BITS         = uer_pkg::COUNT_BITS_DEF,
    parameter int TRIGGER_LOW_TICKS  = uer_pkg::TRIGGER_LOW_TICKS_DEF,
    parameter int TRIGGER_HIGH_TICKS = uer_pkg::TRIGGER_HIGH_TICKS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [uer_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_echo_level,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_trigger_level,
    output logic                                  m_sample_valid,
    output logic [uer_pkg::DIST_BITS-1:0]         m_distance_mm,
    output logic [uer_pkg::WIDTH_OUT_BITS-1:0]    m_echo_width_us,
    output logic [1:0]                            m_event_code
);
    import uer_pkg::*;

    cfg_t    cfg_reg;
    result_t result;
    logic    in_valid_reg, in_valid_next;
    logic    echo_reg;
    logic    m_valid_reg, m_valid_next;
    logic    advance;

    assign advance       = in_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready       = ~in_valid_reg | advance;
    assign in_valid_next = (s_valid & s_ready) | (in_valid_reg & ~advance);
    assign m_valid_next  = advance | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            echo_reg <= s_echo_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable              <= 1'b1;
            cfg_reg.measure_interval_us <= INTERVAL_RESET;
            cfg_reg.echo_timeout_us     <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ENABLE:           cfg_reg.enable <= cfg_wdata[0];
                REG_MEASURE_INTERVAL: cfg_reg.measure_interval_us <=
                                          cfg_wdata[INTERVAL_BITS-1:0];
                REG_ECHO_TIMEOUT:     cfg_reg.echo_timeout_us <=
                                          cfg_wdata[TIMEOUT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    uer_core #(
        .COUNT_BITS         (COUNT_BITS),
        .TRIGGER_LOW_TICKS  (TRIGGER_LOW_TICKS),
        .TRIGGER_HIGH_TICKS (TRIGGER_HIGH_TICKS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .echo_level (echo_reg),
        .cfg        (cfg_reg),
        .result     (result)
    );

    assign m_valid         = m_valid_reg;
    assign m_trigger_level = result.trigger_level;
    assign m_sample_valid  = result.sample_valid;
    assign m_distance_mm   = result.distance_mm;
    assign m_echo_width_us = result.echo_width_us;
    assign m_event_code    = result.event_code;

    `UER_ASSERT_NEXT(a_advance_fills_output, aclk, aresetn, advance, m_valid_reg)
    `UER_ASSERT_IMPL(a_sample_clean, aclk, aresetn, m_valid && m_sample_valid,
        (m_event_code == EV_NONE) && (m_echo_width_us != '0))
    `UER_ASSERT_IMPL(a_fault_no_width, aclk, aresetn,
        m_valid && ((m_event_code == EV_NO_RESPONSE) || (m_event_code == EV_STUCK_HIGH)),
        !m_sample_valid && (m_echo_width_us == '0))

endmodule
